// ===== src/sid_pkg.sv =====
// Shared definitions for the pipelined signed divider.
// No dependencies; used by every module of the divider and by its checker.
`timescale 1ns / 1ps

package sid_pkg;

   // Default operand width of the divider.
   localparam int unsigned DATA_BITS_DEFAULT = 32;

   // Control handed from one pipeline stage to the next: the beat arriving
   // from upstream and whether this stage may take it now.
   typedef struct packed {
      logic load;
      logic valid;
   } sid_pipe_ctrl_type;

endpackage

// ===== src/sid_prep.sv =====
// Entry stage of the divider: operand signs, magnitudes and zero detection.
// Depends on sid_pkg.
`timescale 1ns / 1ps

module sid_prep #(
   parameter int unsigned DATA_BITS = sid_pkg::DATA_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sid_pkg::sid_pipe_ctrl_type    ctrl,
   input  logic signed [DATA_BITS-1:0]   numerator,
   input  logic signed [DATA_BITS-1:0]   denominator,
   output logic                          out_valid,
   output logic [DATA_BITS-1:0]          num_mag,
   output logic [DATA_BITS-1:0]          den_mag,
   output logic                          negate,
   output logic                          den_zero
);

   localparam logic [DATA_BITS-1:0] ONE = DATA_BITS'(1);

   logic [DATA_BITS-1:0] num_bits;
   logic [DATA_BITS-1:0] den_bits;
   logic [DATA_BITS-1:0] num_mag_in;
   logic [DATA_BITS-1:0] den_mag_in;
   logic                 negate_in;
   logic                 den_zero_in;

   logic                 valid_ff;
   logic [DATA_BITS-1:0] num_mag_ff;
   logic [DATA_BITS-1:0] den_mag_ff;
   logic                 negate_ff;
   logic                 den_zero_ff;

   always_comb begin
      num_bits    = $unsigned(numerator);
      den_bits    = $unsigned(denominator);
      num_mag_in  = num_bits[DATA_BITS-1] ? (~num_bits + ONE) : num_bits;
      den_mag_in  = den_bits[DATA_BITS-1] ? (~den_bits + ONE) : den_bits;
      negate_in   = num_bits[DATA_BITS-1] ^ den_bits[DATA_BITS-1];
      den_zero_in = (den_bits == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         num_mag_ff  <= num_mag_in;
         den_mag_ff  <= den_mag_in;
         negate_ff   <= negate_in;
         den_zero_ff <= den_zero_in;
      end
   end

   assign out_valid = valid_ff;
   assign num_mag   = num_mag_ff;
   assign den_mag   = den_mag_ff;
   assign negate    = negate_ff;
   assign den_zero  = den_zero_ff;

endmodule

// ===== src/sid_step.sv =====
// One restoring division step: shift in a numerator bit, compare, subtract.
// Depends on sid_pkg. The numerator bits leave the top of the shared
// numerator/quotient word as the quotient bits enter at the bottom.
`timescale 1ns / 1ps

module sid_step #(
   parameter int unsigned DATA_BITS = sid_pkg::DATA_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sid_pkg::sid_pipe_ctrl_type    ctrl,
   input  logic [DATA_BITS-1:0]          rem,
   input  logic [DATA_BITS-1:0]          num_quo,
   input  logic [DATA_BITS-1:0]          den_mag,
   input  logic                          negate,
   input  logic                          den_zero,
   output logic                          out_valid,
   output logic [DATA_BITS-1:0]          out_rem,
   output logic [DATA_BITS-1:0]          out_num_quo,
   output logic [DATA_BITS-1:0]          out_den_mag,
   output logic                          out_negate,
   output logic                          out_den_zero
);

   logic [DATA_BITS-1:0] shifted;
   logic                 fits;
   logic [DATA_BITS-1:0] rem_in;
   logic [DATA_BITS-1:0] num_quo_in;

   logic                 valid_ff;
   logic [DATA_BITS-1:0] rem_ff;
   logic [DATA_BITS-1:0] num_quo_ff;
   logic [DATA_BITS-1:0] den_mag_ff;
   logic                 negate_ff;
   logic                 den_zero_ff;

   // The partial remainder stays below the divisor magnitude, which is at
   // most half the range, so the shifted value always fits the word.
   always_comb begin
      shifted    = {rem[DATA_BITS-2:0], num_quo[DATA_BITS-1]};
      fits       = (shifted >= den_mag);
      rem_in     = fits ? (shifted - den_mag) : shifted;
      num_quo_in = {num_quo[DATA_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rem_ff      <= rem_in;
         num_quo_ff  <= num_quo_in;
         den_mag_ff  <= den_mag;
         negate_ff   <= negate;
         den_zero_ff <= den_zero;
      end
   end

   assign out_valid    = valid_ff;
   assign out_rem      = rem_ff;
   assign out_num_quo  = num_quo_ff;
   assign out_den_mag  = den_mag_ff;
   assign out_negate   = negate_ff;
   assign out_den_zero = den_zero_ff;

endmodule

// ===== src/sid_post.sv =====
// Output stage of the divider: sign, overflow and zero-divisor handling.
// Depends on sid_pkg; its registers drive the result channel directly.
`timescale 1ns / 1ps

module sid_post #(
   parameter int unsigned DATA_BITS = sid_pkg::DATA_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sid_pkg::sid_pipe_ctrl_type    ctrl,
   input  logic [DATA_BITS-1:0]          quo_mag,
   input  logic                          negate,
   input  logic                          den_zero,
   output logic                          out_valid,
   output logic signed [DATA_BITS-1:0]   quotient
);

   localparam logic [DATA_BITS-1:0] ONE = DATA_BITS'(1);

   logic                 overflow;
   logic [DATA_BITS-1:0] quotient_in;

   logic                 valid_ff;
   logic [DATA_BITS-1:0] quotient_ff;

   // A positive result with the top bit set is reached by the most negative
   // value divided by minus one, or by a non-negative value divided by zero.
   always_comb begin
      overflow = !negate && quo_mag[DATA_BITS-1];
      if (den_zero || overflow) begin
         quotient_in = '0;
      end else if (negate) begin
         quotient_in = ~quo_mag + ONE;
      end else begin
         quotient_in = quo_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         quotient_ff <= quotient_in;
      end
   end

   assign out_valid = valid_ff;
   assign quotient  = $signed(quotient_ff);

endmodule

// ===== src/signed_int32_divider_core.sv =====
// Top level of the pipelined signed divider with truncation toward zero.
// Depends on sid_pkg, sid_prep, sid_step and sid_post.
`timescale 1ns / 1ps
//
//   Channel   Direction   Handshake            Payload
//   req       in          req_valid/req_stall  req_numerator, req_denominator
//   rsp       out         rsp_valid/rsp_stall  rsp_quotient
//
// The pipeline has one entry stage, one restoring step per quotient bit and
// one output stage. A new beat can enter in each cycle that req_stall is low.
// Each stage holds its own valid bit, and a stage loads whenever it is
// empty or the stage after it loads, so bubbles close up under a stall and
// req_stall rises only when every stage holds a beat and rsp_stall is high.
// Reset clears all valid bits; the data registers are not reset.

module signed_int32_divider_core #(
   parameter int unsigned DATA_BITS = sid_pkg::DATA_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_BITS-1:0]  req_numerator,
   input  logic signed [DATA_BITS-1:0]  req_denominator,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_BITS-1:0]  rsp_quotient
);

   // Stage numbering: 0 is the entry stage, 1 to DATA_BITS are the division
   // steps, and DATA_BITS + 1 is the output stage.
   localparam int unsigned LAST = DATA_BITS + 1;

   logic [LAST:0]   stage_valid;
   logic [LAST+1:0] stage_load;

   logic [DATA_BITS-1:0] rem_w     [0:DATA_BITS];
   logic [DATA_BITS-1:0] num_quo_w [0:DATA_BITS];
   logic [DATA_BITS-1:0] den_mag_w [0:DATA_BITS];
   logic                 negate_w  [0:DATA_BITS];
   logic                 zero_w    [0:DATA_BITS];

   sid_pkg::sid_pipe_ctrl_type prep_ctrl;
   sid_pkg::sid_pipe_ctrl_type post_ctrl;

   // A stage may take a beat when it is empty or its content moves on.
   assign stage_load[LAST+1] = !rsp_stall;

   genvar s;
   generate
      for (s = 0; s <= LAST; s++) begin : g_load
         assign stage_load[s] = !stage_valid[s] || stage_load[s+1];
      end
   endgenerate

   assign req_stall = !stage_load[0];

   assign prep_ctrl.load  = stage_load[0];
   assign prep_ctrl.valid = req_valid;

   sid_prep #(
      .DATA_BITS (DATA_BITS)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (prep_ctrl),
      .numerator   (req_numerator),
      .denominator (req_denominator),
      .out_valid   (stage_valid[0]),
      .num_mag     (num_quo_w[0]),
      .den_mag     (den_mag_w[0]),
      .negate      (negate_w[0]),
      .den_zero    (zero_w[0])
   );

   // The partial remainder starts at zero for every beat.
   assign rem_w[0] = '0;

   genvar g;
   generate
      for (g = 0; g < DATA_BITS; g++) begin : g_step
         sid_pkg::sid_pipe_ctrl_type step_ctrl;

         assign step_ctrl.load  = stage_load[g+1];
         assign step_ctrl.valid = stage_valid[g];

         sid_step #(
            .DATA_BITS (DATA_BITS)
         ) u_step (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (step_ctrl),
            .rem          (rem_w[g]),
            .num_quo      (num_quo_w[g]),
            .den_mag      (den_mag_w[g]),
            .negate       (negate_w[g]),
            .den_zero     (zero_w[g]),
            .out_valid    (stage_valid[g+1]),
            .out_rem      (rem_w[g+1]),
            .out_num_quo  (num_quo_w[g+1]),
            .out_den_mag  (den_mag_w[g+1]),
            .out_negate   (negate_w[g+1]),
            .out_den_zero (zero_w[g+1])
         );
      end
   endgenerate

   assign post_ctrl.load  = stage_load[LAST];
   assign post_ctrl.valid = stage_valid[DATA_BITS];

   // After the last step the shared word holds the quotient magnitude; the
   // final remainder is not needed.
   sid_post #(
      .DATA_BITS (DATA_BITS)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (post_ctrl),
      .quo_mag   (num_quo_w[DATA_BITS]),
      .negate    (negate_w[DATA_BITS]),
      .den_zero  (zero_w[DATA_BITS]),
      .out_valid (stage_valid[LAST]),
      .quotient  (rsp_quotient)
   );

   assign rsp_valid = stage_valid[LAST];

endmodule

// ===== src/sid_checker.sv =====
// Port-level checker for the pipelined signed divider, bound to its top level.
// Depends on sid_pkg and signed_int32_divider_core.
`timescale 1ns / 1ps

module sid_checker #(
   parameter int unsigned DATA_BITS = sid_pkg::DATA_BITS_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic signed [DATA_BITS-1:0]  req_numerator,
   input logic signed [DATA_BITS-1:0]  req_denominator,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [DATA_BITS-1:0]  rsp_quotient
);

   // LAT is the distance from the edge that takes a beat to the edge that
   // samples its result on the result side when nothing holds it up.
   localparam int unsigned LAT      = DATA_BITS + 2;
   localparam int unsigned CNT_BITS = $clog2(DATA_BITS + 1) + 1;

   logic [CNT_BITS-1:0] run_cnt_ff;
   logic [CNT_BITS-1:0] run_cnt_in;
   logic                run_ok;
   logic                take;

   // Counts consecutive edges without a result stall since reset.
   always_comb begin
      if (rsp_stall) begin
         run_cnt_in = '0;
      end else if (run_cnt_ff >= CNT_BITS'(DATA_BITS + 1)) begin
         run_cnt_in = run_cnt_ff;
      end else begin
         run_cnt_in = run_cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff <= '0;
      end else begin
         run_cnt_ff <= run_cnt_in;
      end
   end

   assign run_ok = (run_cnt_ff >= CNT_BITS'(DATA_BITS + 1));
   assign take   = req_valid && !req_stall && !reset;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quotient))
      else $error("stalled result beat changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_backpressure: assert property (@(posedge clock)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while the result side is free");

   a_zero_divisor: assert property (@(posedge clock) disable iff (reset)
      run_ok && $past(take && (req_denominator == '0), LAT)
      |-> rsp_valid && (rsp_quotient == '0))
      else $error("division by zero did not give zero");

   a_unit_divisor: assert property (@(posedge clock) disable iff (reset)
      run_ok && $past(take && (req_denominator == DATA_BITS'(1)), LAT)
      |-> rsp_valid && (rsp_quotient == $past(req_numerator, LAT)))
      else $error("division by one did not return the numerator");

endmodule

bind signed_int32_divider_core sid_checker #(
   .DATA_BITS (DATA_BITS)
) u_sid_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_numerator   (req_numerator),
   .req_denominator (req_denominator),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_quotient    (rsp_quotient)
);

// ===== tb/tb.sv =====
// Self-checking bench for signed_int32_divider_core: truncated signed division.
// Depends on sid_pkg and the divider RTL; drives both channels with random idling.
`timescale 1ns / 1ps

module tb;

   localparam int W = sid_pkg::DATA_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BEATS = 626;
   localparam int HOLD_OFF_CYCLES = 160;
   localparam int SETTLE_CYCLES = W + 16;

   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};

   // One row of the directed table. When has_quo is set, quo was written in by
   // hand; otherwise the expected quotient comes from trunc_quotient.
   typedef struct {
      logic [W-1:0] num;
      logic [W-1:0] den;
      bit           has_quo;
      logic [W-1:0] quo;
   } div_case_type;

   localparam int DIRECTED_ROWS = 24;

   div_case_type directed_cases [0:DIRECTED_ROWS-1] = '{
      // Zero divisor always gives zero.
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{32'h0000_0007, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{MOST_NEG,      32'h0000_0000, 1'b1, 32'h0000_0000},
      // The one unrepresentable quotient is forced to zero.
      '{MOST_NEG,      MINUS_ONE,     1'b1, 32'h0000_0000},
      '{MOST_NEG,      32'h0000_0001, 1'b1, MOST_NEG},
      '{MOST_POS,      32'h0000_0001, 1'b1, MOST_POS},
      '{MOST_POS,      MINUS_ONE,     1'b1, 32'h8000_0001},
      '{MOST_NEG,      MOST_NEG,      1'b1, 32'h0000_0001},
      '{MOST_POS,      MOST_POS,      1'b1, 32'h0000_0001},
      '{MOST_NEG,      MOST_POS,      1'b1, 32'hFFFF_FFFF},
      '{MOST_POS,      MOST_NEG,      1'b1, 32'h0000_0000},
      // Every sign combination, truncating toward zero.
      '{32'hFFFF_FFF9, 32'h0000_0002, 1'b0, 32'h0000_0000},
      '{32'h0000_0007, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000},
      '{32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000},
      '{32'h0000_0007, 32'h0000_0002, 1'b0, 32'h0000_0000},
      '{MINUS_ONE,     MINUS_ONE,     1'b0, 32'h0000_0000},
      '{32'h0000_0000, MOST_NEG,      1'b1, 32'h0000_0000},
      '{32'h0000_0001, MOST_POS,      1'b1, 32'h0000_0000},
      '{MOST_NEG,      32'h0000_0002, 1'b1, 32'hC000_0000},
      '{MOST_NEG,      32'hFFFF_FFFE, 1'b1, 32'h4000_0000},
      '{32'h0000_0064, 32'h0000_0007, 1'b0, 32'h0000_0000},
      '{32'h1234_5678, 32'h0000_0101, 1'b0, 32'h0000_0000},
      '{32'hAAAA_AAAA, 32'h0000_5555, 1'b0, 32'h0000_0000},
      '{32'h5555_5555, 32'hFFFF_FFFD, 1'b0, 32'h0000_0000}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   logic [W-1:0] req_numerator = '0;
   logic [W-1:0] req_denominator = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic [W-1:0] rsp_quotient;

   // Expected quotient of the beat now on the request port; the monitor files
   // it away in the cycle that the beat is taken.
   logic [W-1:0] offered_quotient = '0;
   logic [W-1:0] pending_quotients [$];

   int  fail_count = 0;
   int  cycle_count = 0;
   bit  calm = 1'b0;
   bit  hold_off_now = 1'b0;

   signed_int32_divider_core #(
      .DATA_BITS (W)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_numerator   (req_numerator),
      .req_denominator (req_denominator),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_quotient    (rsp_quotient)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Restoring division on the operand magnitudes, one quotient bit per pass,
   // with the remainder kept one bit wider than the operands so that the
   // compare never wraps. The sign is the XOR of the operand signs.
   function automatic logic [W-1:0] trunc_quotient(input logic [W-1:0] num,
                                                   input logic [W-1:0] den);
      logic         flip;
      logic [W-1:0] num_mag;
      logic [W-1:0] den_mag;
      logic [W-1:0] quo;
      logic [W:0]   part;
      flip = num[W-1] ^ den[W-1];
      num_mag = num[W-1] ? -num : num;
      den_mag = den[W-1] ? -den : den;
      if (den_mag == '0) begin
         return '0;
      end
      part = '0;
      quo = '0;
      for (int i = W - 1; i >= 0; i--) begin
         part = {part[W-1:0], num_mag[i]};
         if (part >= {1'b0, den_mag}) begin
            part = part - {1'b0, den_mag};
            quo[i] = 1'b1;
         end
      end
      // A positive quotient with the top bit set only comes from the most
      // negative value divided by minus one, which is not representable.
      if (!flip && quo[W-1]) begin
         return '0;
      end
      return flip ? -quo : quo;
   endfunction

   // Offer one beat and hold it until the divider takes it.
   task automatic send_beat(input logic [W-1:0] num, input logic [W-1:0] den,
                            input logic [W-1:0] quo);
      req_valid <= 1'b1;
      req_numerator <= num;
      req_denominator <= den;
      offered_quotient <= quo;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Scoreboard. Handshakes are judged on the values from before the edge, so
   // the order of processes inside a time step does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_quotients.push_back(offered_quotient);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_quotients.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected result beat: quotient %h", rsp_quotient);
               end
               fail_count++;
            end else begin
               if (rsp_quotient !== pending_quotients[0]) begin
                  if (fail_count < 10) begin
                     $display("quotient mismatch: expected %h, actual %h",
                              pending_quotients[0], rsp_quotient);
                  end
                  fail_count++;
               end
               void'(pending_quotients.pop_front());
            end
         end
      end
   end

   // Result side. The stall rate is re-picked after every 128 decisions, so
   // there are stretches with no back-pressure at all. On request from the
   // stimulus process the receiver stalls for a long, fixed stretch so the
   // pipeline fills up and pushes back on the request side.
   initial begin
      int rate_pct;
      int cycles_left;
      rate_pct = 0;
      cycles_left = 0;
      wait (!reset);
      forever begin
         if (cycles_left == 0) begin
            case ($urandom_range(0, 2))
               0: rate_pct = 0;
               1: rate_pct = 8;
               default: rate_pct = 30;
            endcase
            cycles_left = 128;
         end
         if (hold_off_now) begin
            hold_off_now = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (!calm && $urandom_range(0, 99) < rate_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
         cycles_left = (cycles_left > 0) ? cycles_left - 1 : 0;
      end
   end

   // Reset, then the directed table, then random beats in phases.
   initial begin
      logic [W-1:0] num;
      logic [W-1:0] den;
      logic [W-1:0] quo;
      logic [W-1:0] special_values [0:5];
      int           gap_pct;
      int           small_den;
      special_values = '{32'h0000_0000, 32'h0000_0001, MINUS_ONE, MOST_NEG,
                         MOST_POS, 32'h0000_0002};
      gap_pct = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_cases[k]) begin
         quo = directed_cases[k].has_quo ? directed_cases[k].quo
                                         : trunc_quotient(directed_cases[k].num,
                                                          directed_cases[k].den);
         send_beat(directed_cases[k].num, directed_cases[k].den, quo);
      end

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         // Sender idling rate changes every 50 beats; the segment starting at
         // beat 200 offers back to back while the receiver holds off.
         if (i % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: gap_pct = 0;
               1: gap_pct = 15;
               default: gap_pct = 40;
            endcase
            if (i == 200) begin
               gap_pct = 0;
               hold_off_now = 1'b1;
            end
         end
         // Pause here until every result in flight has come back.
         if (i == 400) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_quotients.size() != 0) begin
               @(posedge clock);
            end
         end
         // The last hundred beats run with no idling on either side.
         if (i == RANDOM_BEATS - 100) begin
            calm = 1'b1;
         end

         num = $urandom;
         den = $urandom;
         case ($urandom_range(0, 5))
            0: begin
               // Full-range operands, as drawn.
            end
            1: begin
               small_den = $urandom_range(0, 16);
               den = $urandom_range(0, 1) ? -small_den : small_den;
            end
            2: begin
               num = special_values[$urandom_range(0, 5)];
               den = special_values[$urandom_range(0, 5)];
            end
            3: begin
               // Divisor magnitudes spread over every bit length.
               den = $signed(den) >>> $urandom_range(0, W - 1);
            end
            4: begin
               // Numerator close to a small multiple of the divisor.
               den = $signed(den) >>> $urandom_range(8, W - 2);
               num = den * $urandom_range(0, 300) + $urandom_range(0, 3) - 1;
            end
            default: begin
               num = $signed(num) >>> $urandom_range(0, W - 1);
            end
         endcase

         if (!calm && $urandom_range(0, 99) < gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         send_beat(num, den, trunc_quotient(num, den));
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_quotients.size() != 0) begin
         @(posedge clock);
      end
      // Give a stray extra beat time to show up on the result port.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_quotients.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/sid_pkg.sv
src/sid_prep.sv
src/sid_step.sv
src/sid_post.sv
src/signed_int32_divider_core.sv
src/sid_checker.sv
tb/tb.sv
